/* hdl/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the status frame deframer
// Result codes, header geometry, configuration and result records.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned HdrBytes  = 8;
  localparam int unsigned CountW    = 4;
  localparam int unsigned ShiftW    = 8 * (HdrBytes - 1);

  localparam logic [2:0] ST_PAYLOAD = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_BADHDR  = 3'd2;
  localparam logic [2:0] ST_TOOLONG = 3'd3;
  localparam logic [2:0] ST_FAILED  = 3'd4;

  localparam logic [1:0] REG_MAGIC   = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_MAXLEN  = 2'd2;

  localparam logic [15:0] MAXLEN_RESET = 16'd4096;

  typedef struct packed {
    logic [31:0] magic;
    logic [7:0]  version;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  frame_type;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    logic        last_of_frame;
  } result_t;

endpackage

/* hdl/sfd_parse.sv */
// ----------------------------------------------------------------------------
// sfd_parse: header and payload tracking
// Consumes one byte per advance, updates frame state, forms at most one result.
// ----------------------------------------------------------------------------
module sfd_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       data_byte,
  input  sfd_pkg::cfg_t    cfg,
  output logic             res_valid,
  output sfd_pkg::result_t res,
  output logic             failed
);
  import sfd_pkg::*;

  logic [ShiftW-1:0] header_shift, header_shift_next;
  logic [CountW-1:0] header_count, header_count_next;
  logic [15:0]       payload_remaining, payload_remaining_next;
  logic [7:0]        current_type, current_type_next;
  logic [15:0]       current_length, current_length_next;
  logic              failed_next;
  logic [63:0]       full_hdr;
  logic [15:0]       rem_dec;

  assign full_hdr = {header_shift, data_byte};
  assign rem_dec  = payload_remaining - 16'd1;

  always_comb begin
    header_shift_next      = header_shift;
    header_count_next      = header_count;
    payload_remaining_next = payload_remaining;
    current_type_next      = current_type;
    current_length_next    = current_length;
    failed_next            = failed;
    res_valid              = 1'b0;
    res.status             = ST_FAILED;
    res.payload_byte       = 8'd0;
    res.last_of_frame      = 1'b0;
    if (failed) begin
      res_valid = 1'b1;
    end else if (header_count < CountW'(HdrBytes)) begin
      header_shift_next = full_hdr[ShiftW-1:0];
      header_count_next = header_count + CountW'(1);
      if (header_count == CountW'(HdrBytes - 1)) begin
        current_type_next   = full_hdr[23:16];
        current_length_next = full_hdr[15:0];
        if (full_hdr[63:32] != cfg.magic || full_hdr[31:24] != cfg.version) begin
          failed_next = 1'b1;
          res_valid   = 1'b1;
          res.status  = ST_BADHDR;
        end else if (full_hdr[15:0] > cfg.max_payload) begin
          failed_next = 1'b1;
          res_valid   = 1'b1;
          res.status  = ST_TOOLONG;
        end else if (full_hdr[15:0] == 16'd0) begin
          header_count_next = '0;
          res_valid         = 1'b1;
          res.status        = ST_EMPTY;
          res.last_of_frame = 1'b1;
        end else begin
          payload_remaining_next = full_hdr[15:0];
        end
      end
    end else begin
      payload_remaining_next = rem_dec;
      res_valid              = 1'b1;
      res.status             = ST_PAYLOAD;
      res.payload_byte       = data_byte;
      if (rem_dec == 16'd0) begin
        header_count_next = '0;
        res.last_of_frame = 1'b1;
      end
    end
    res.frame_type     = current_type_next;
    res.payload_length = current_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_shift      <= '0;
      header_count      <= '0;
      payload_remaining <= '0;
      current_type      <= '0;
      current_length    <= '0;
      failed            <= 1'b0;
    end else if (advance) begin
      header_shift      <= header_shift_next;
      header_count      <= header_count_next;
      payload_remaining <= payload_remaining_next;
      current_type      <= current_type_next;
      current_length    <= current_length_next;
      failed            <= failed_next;
    end
  end

endmodule

/* hdl/sfd_outq.sv */
// ----------------------------------------------------------------------------
// sfd_outq: two-entry result queue
// Holds finished results so the parser keeps running while the sink stalls.
// ----------------------------------------------------------------------------
module sfd_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfd_pkg::result_t push_data,
  output logic             has_space,
  output logic             out_valid,
  input  logic             out_ready,
  output sfd_pkg::result_t out_data
);
  import sfd_pkg::*;

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign has_space = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hdl/status_frame_deframer_unit.sv */
// ----------------------------------------------------------------------------
// status_frame_deframer_unit: length-prefixed status frame deframer
// Splits a byte stream into frames with an 8-byte big-endian header.
//
// Input channel: in_valid/in_ready with data_byte, one beat per stream byte.
// Output channel: out_valid/out_ready with status, frame_type, payload_byte,
// payload_length and last_of_frame. Header bytes give no beat except the
// eighth when the frame fails or is empty; every payload byte gives one.
// Configuration: cfg_write with cfg_index and cfg_data, write only while idle.
// Index 0 magic, 1 version, 2 max payload; other indexes are ignored.
// Path: each byte is registered in the input register and its result in the queue.
// Throughput: one byte per cycle while the queue has space, set by the
// combinational parser step between the input register and the two-entry queue.
// Reset: clears frame state, the failed flag and the queue; registers go to
// magic 0, version 0, max payload 4096.
// Stall: the queue absorbs results; once it is full and the input register
// holds a byte, in_ready drops until the sink takes a beat.
// After a bad header or oversize length every byte returns status 4 until reset.
// ----------------------------------------------------------------------------
module status_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  frame_type,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_length,
  output logic        last_of_frame,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sfd_pkg::*;

  cfg_t    cfg;
  logic    in_reg_valid;
  logic [7:0] in_reg_byte;
  logic    advance;
  logic    has_space;
  logic    res_valid;
  result_t res;
  result_t out_data;
  logic    failed;

  assign advance  = in_reg_valid && has_space;
  assign in_ready = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic       <= '0;
      cfg.version     <= '0;
      cfg.max_payload <= MAXLEN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAGIC:   cfg.magic       <= cfg_data;
        REG_VERSION: cfg.version     <= cfg_data[7:0];
        REG_MAXLEN:  cfg.max_payload <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_reg_byte <= data_byte;
    end
  end

  sfd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data_byte (in_reg_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res),
    .failed    (failed)
  );

  sfd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && res_valid),
    .push_data (res),
    .has_space (has_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign status         = out_data.status;
  assign frame_type     = out_data.frame_type;
  assign payload_byte   = out_data.payload_byte;
  assign payload_length = out_data.payload_length;
  assign last_of_frame  = out_data.last_of_frame;

  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    failed |=> failed)
    else $error("failed flag dropped without reset");

  a_byte_only_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_PAYLOAD |-> payload_byte == 8'd0)
    else $error("payload byte nonzero on non-payload result");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_frame |-> (status == ST_PAYLOAD || status == ST_EMPTY))
    else $error("last marker on error result");

  a_failed_output: assert property (@(posedge clk) disable iff (rst)
    advance && failed |-> res_valid && res.status == ST_FAILED)
    else $error("byte after failure not reported as already failed");

endmodule

/* dv/sfd_stream_checker.sv */
// ----------------------------------------------------------------------------
// sfd_stream_checker: result checker for the status frame deframer
// Watches the byte, result and register ports at every clock edge. Keeps its
// own copy of the header parser state and the registers, predicts the result
// beat, if any, of each accepted byte, and compares every result beat field
// by field against the oldest prediction. Reports mismatches and unexpected
// beats, and keeps a count of failures for the testbench top.
// ----------------------------------------------------------------------------
module sfd_stream_checker
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [7:0]  frame_type,
  input  logic [7:0]  payload_byte,
  input  logic [15:0] payload_length,
  input  logic        last_of_frame,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          awaiting,
  output int          beats_checked
);

  localparam int PrintCap = 40;

  cfg_t        cfg;
  logic [63:0] hdr_shift;
  logic [3:0]  hdr_count;
  logic [15:0] remaining;
  logic [7:0]  cur_type;
  logic [15:0] cur_len;
  logic        failed;
  result_t     expected_beats[$];
  result_t     got_beat;
  result_t     want_beat;

  function automatic void queue_result(input logic [2:0] st, input logic [7:0] pb,
                                       input logic last);
    result_t r;
    r.status         = st;
    r.frame_type     = cur_type;
    r.payload_byte   = pb;
    r.payload_length = cur_len;
    r.last_of_frame  = last;
    expected_beats.push_back(r);
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    if (failed) begin
      queue_result(ST_FAILED, 8'h00, 1'b0);
    end else if (hdr_count < HdrBytes) begin
      hdr_shift = {hdr_shift[55:0], b};
      hdr_count = hdr_count + 4'd1;
      if (hdr_count == HdrBytes) begin
        cur_type = hdr_shift[23:16];
        cur_len  = hdr_shift[15:0];
        if (hdr_shift[63:32] != cfg.magic || hdr_shift[31:24] != cfg.version) begin
          failed = 1'b1;
          queue_result(ST_BADHDR, 8'h00, 1'b0);
        end else if (cur_len > cfg.max_payload) begin
          failed = 1'b1;
          queue_result(ST_TOOLONG, 8'h00, 1'b0);
        end else if (cur_len == 16'd0) begin
          hdr_count = '0;
          queue_result(ST_EMPTY, 8'h00, 1'b1);
        end else begin
          remaining = cur_len;
        end
      end
    end else begin
      remaining = remaining - 16'd1;
      if (remaining == 16'd0) begin
        hdr_count = '0;
        queue_result(ST_PAYLOAD, b, 1'b1);
      end else begin
        queue_result(ST_PAYLOAD, b, 1'b0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.magic       = '0;
      cfg.version     = '0;
      cfg.max_payload = MAXLEN_RESET;
      hdr_shift       = '0;
      hdr_count       = '0;
      remaining       = '0;
      cur_type        = '0;
      cur_len         = '0;
      failed          = 1'b0;
      expected_beats.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MAGIC:   cfg.magic       = cfg_data;
          REG_VERSION: cfg.version     = cfg_data[7:0];
          REG_MAXLEN:  cfg.max_payload = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        deframe_byte(data_byte);
      end
      if (out_valid && out_ready) begin
        got_beat.status         = status;
        got_beat.frame_type     = frame_type;
        got_beat.payload_byte   = payload_byte;
        got_beat.payload_length = payload_length;
        got_beat.last_of_frame  = last_of_frame;
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= PrintCap) begin
            $display("%0t: unexpected beat st=%0d type=%02h byte=%02h len=%0d last=%0b",
                     $time, got_beat.status, got_beat.frame_type, got_beat.payload_byte,
                     got_beat.payload_length, got_beat.last_of_frame);
          end
        end else begin
          want_beat = expected_beats.pop_front();
          beats_checked++;
          if (got_beat.status !== want_beat.status ||
              got_beat.frame_type !== want_beat.frame_type ||
              got_beat.payload_byte !== want_beat.payload_byte ||
              got_beat.payload_length !== want_beat.payload_length ||
              got_beat.last_of_frame !== want_beat.last_of_frame) begin
            mismatches++;
            if (mismatches <= PrintCap) begin
              $display("%0t: mismatch expected st=%0d type=%02h byte=%02h len=%0d last=%0b",
                       $time, want_beat.status, want_beat.frame_type,
                       want_beat.payload_byte, want_beat.payload_length,
                       want_beat.last_of_frame);
              $display("%0t:          actual st=%0d type=%02h byte=%02h len=%0d last=%0b",
                       $time, got_beat.status, got_beat.frame_type, got_beat.payload_byte,
                       got_beat.payload_length, got_beat.last_of_frame);
            end
          end
        end
      end
    end
    awaiting <= expected_beats.size();
  end

endmodule

/* dv/status_frame_deframer_unit_tb.sv */
// ----------------------------------------------------------------------------
// status_frame_deframer_unit_tb: testbench top for the status frame deframer
// Drives the byte stream and the register port, paces the result sink, and
// reports the verdict. Starts with a few hand-built frames on the reset
// registers, then runs random well-formed frames under seven register
// settings, the last six each switched in the middle of a header, with
// idle and stall patterns on both channels and one long sink hold-off. The
// stream ends with one broken header (bad magic, bad version or oversize
// length) followed by noise bytes that must all come back as already failed.
// ----------------------------------------------------------------------------
module status_frame_deframer_unit_tb;
  import sfd_pkg::*;

  localparam int         HoldCycles   = 300;
  localparam int         SettleCycles = 6;
  localparam int         StallLimit   = 2000;
  localparam int         PhaseBytes   = 75;
  localparam int         NoiseBytes   = 48;
  localparam logic [1:0] REG_SPARE    = 2'd3;

  logic        clk;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic [7:0]  data_byte      = 8'h00;
  logic        out_ready      = 1'b0;
  logic        cfg_write      = 1'b0;
  logic [1:0]  cfg_index      = 2'd0;
  logic [31:0] cfg_data       = 32'd0;
  logic        in_ready;
  logic        out_valid;
  logic [2:0]  status;
  logic [7:0]  frame_type;
  logic [7:0]  payload_byte;
  logic [15:0] payload_length;
  logic        last_of_frame;

  int    mismatches;
  int    awaiting;
  int    beats_checked;
  int    send_idle_pct  = 0;
  int    sink_stall_pct = 0;
  int    hold_left      = 0;
  bit    hold_now       = 1'b0;
  int    idle_cycles    = 0;
  int    bytes_sent     = 0;
  int    frames_sent    = 0;
  cfg_t  live_cfg;
  string close_kind;

  status_frame_deframer_unit uut (.*);

  sfd_stream_checker stream_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_now) begin
        hold_now  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("status_frame_deframer_unit verification failed");
    $finish;
  end

  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [63:0] hdr, input int from, input int upto);
    for (int i = from; i < upto; i++) begin
      put_byte(hdr[63 - 8*i -: 8]);
    end
  endtask

  task automatic send_payload(input int len);
    for (int i = 0; i < len; i++) begin
      put_byte(8'($urandom_range(255)));
    end
    frames_sent++;
  endtask

  function automatic logic [63:0] frame_header(input cfg_t c, input logic [7:0] ftype,
                                               input logic [15:0] len);
    return {c.magic, c.version, ftype, len};
  endfunction

  function automatic logic [15:0] pick_length(input logic [15:0] limit);
    int unsigned roll;
    int unsigned cap;
    roll = $urandom_range(99);
    if (roll < 10 || limit == 16'd0) return 16'd0;
    if (roll >= 92) return (limit <= 400) ? limit : 16'($urandom_range(400, 200));
    cap = (roll < 70) ? 16 : 160;
    return 16'($urandom_range((limit < cap) ? limit : cap));
  endfunction

  task automatic send_random_frame;
    logic [15:0] len;
    len = pick_length(live_cfg.max_payload);
    send_header(frame_header(live_cfg, 8'($urandom), len), 0, 8);
    send_payload(len);
  endtask

  task automatic run_phase(input int budget);
    int stop_at;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      send_random_frame();
    end
  endtask

  // hold the input low until every predicted beat is out and the pipe is empty
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(REG_MAGIC, c.magic);
    write_reg(REG_VERSION, {24'($urandom), c.version});
    write_reg(REG_MAXLEN, {16'($urandom), c.max_payload});
    if ($urandom_range(1) == 1) begin
      write_reg(REG_SPARE, $urandom);
    end
    cfg_write <= 1'b0;
    live_cfg = c;
  endtask

  // start a header built for the new settings, then load them mid-header
  task automatic switch_config(input cfg_t c);
    logic [15:0] len;
    logic [63:0] hdr;
    int          split;
    len   = pick_length(c.max_payload);
    hdr   = frame_header(c, 8'($urandom), len);
    split = $urandom_range(7, 1);
    send_header(hdr, 0, split);
    drain();
    load_config(c);
    send_header(hdr, split, 8);
    send_payload(len);
  endtask

  initial begin
    cfg_t        next_cfg;
    logic [63:0] hdr;
    int          close_sel;

    live_cfg.magic       = '0;
    live_cfg.version     = '0;
    live_cfg.max_payload = MAXLEN_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_SPARE, $urandom);
    cfg_write <= 1'b0;

    send_header(frame_header(live_cfg, 8'hFF, 16'd0), 0, 8);
    frames_sent++;
    send_header(frame_header(live_cfg, 8'h00, 16'd1), 0, 8);
    put_byte(8'hFF);
    frames_sent++;
    send_header(frame_header(live_cfg, 8'hA5, 16'd2), 0, 8);
    put_byte(8'h00);
    put_byte(8'h5A);
    frames_sent++;

    hold_now = 1'b1;
    send_header(frame_header(live_cfg, 8'h3C, 16'd120), 0, 8);
    send_payload(120);
    run_phase(PhaseBytes);

    for (int p = 1; p <= 6; p++) begin
      case (p)
        1:       next_cfg = '{32'hFFFF_FFFF, 8'hFF, 16'd0};
        2:       next_cfg = '{$urandom, 8'($urandom), 16'hFFFF};
        3:       next_cfg = '{32'd0, 8'd0, 16'($urandom_range(8, 1))};
        4:       next_cfg = '{$urandom, 8'($urandom), 16'($urandom)};
        5:       next_cfg = '{$urandom, 8'($urandom), MAXLEN_RESET};
        default: next_cfg = '{$urandom, 8'($urandom), 16'($urandom_range(300, 16))};
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 55; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 55; end
        default: begin send_idle_pct = 34; sink_stall_pct = 34; end
      endcase
      switch_config(next_cfg);
      run_phase(PhaseBytes);
    end

    close_sel = $urandom_range(2);
    case (close_sel)
      0: begin
        hdr = {live_cfg.magic ^ (32'd1 << $urandom_range(31)), live_cfg.version,
               8'($urandom), 16'($urandom)};
        close_kind = "bad magic";
      end
      1: begin
        hdr = {live_cfg.magic, live_cfg.version ^ (8'd1 << $urandom_range(7)),
               8'($urandom), 16'($urandom)};
        close_kind = "bad version";
      end
      default: begin
        if (live_cfg.max_payload == 16'hFFFF) begin
          drain();
          next_cfg             = live_cfg;
          next_cfg.max_payload = 16'($urandom_range(65534));
          load_config(next_cfg);
        end
        hdr = frame_header(live_cfg, 8'($urandom),
                           16'($urandom_range(65535, live_cfg.max_payload + 1)));
        close_kind = "oversize length";
      end
    endcase
    send_header(hdr, 0, 8);
    repeat (NoiseBytes) put_byte(8'($urandom));

    drain();
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d bytes in %0d good frames under seven register settings; %0d beats checked.",
             bytes_sent, frames_sent, beats_checked);
    $display("Stream closed by a %s header and %0d bytes after the failure.",
             close_kind, NoiseBytes);
    if (mismatches == 0) begin
      $display("status_frame_deframer_unit verification clean");
    end else begin
      $display("status_frame_deframer_unit verification failed");
    end
    $finish;
  end

endmodule
